// ===== rtl/core/vepl_pkg.sv =====
// Package for the virtual encoder position loop: field widths, stream packing
// offsets, configuration register indexes and the per-wheel state record.
// No dependencies.
`default_nettype none

package vepl_pkg;

	localparam int WHEELS     = 4;
	localparam int WHEEL_W    = 2;
	localparam int SPEED_W    = 16;
	localparam int ANGLE_W    = 13;
	localparam int DELTA_W    = 14;
	localparam int ERR_W      = 32;
	localparam int GAIN_W     = 16;
	localparam int LIMIT_W    = 15;
	localparam int DBAND_W    = 10;
	localparam int WRAP_BAND  = 3000;
	localparam int ENC_COUNTS = 1 << ANGLE_W;

	// input tdata: target_speed_0..3, now_angle_0..3, angle_delta_0..3
	localparam int NOW_LSB   = WHEELS * SPEED_W;
	localparam int DELTA_LSB = NOW_LSB + WHEELS * ANGLE_W;
	localparam int IN_BITS   = DELTA_LSB + WHEELS * DELTA_W;
	localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;

	// output tdata: speed_cmd_0..3, correction_0..3
	localparam int CORR_LSB = WHEELS * SPEED_W;
	localparam int OUT_W    = 2 * WHEELS * SPEED_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_KP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KD    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DBAND = 3'd4;

	typedef struct packed {
		logic [ANGLE_W-1:0] vpos;
		logic [ERR_W-1:0]   pend;
		logic [ERR_W-1:0]   prev;
	} wheel_state_t;

	localparam int STATE_W = $bits(wheel_state_t);

endpackage

`default_nettype wire

// ===== rtl/core/vepl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vepl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/virtual_encoder_position_loop.sv =====
// Virtual encoder position loop, four wheels, one shared multiplier.
// Depends on vepl_pkg and vepl_ram (per-wheel state memory).
//
//  port group     dir  payload (low bit first)
//  s_*  request   in   target_speed_0..3, now_angle_0..3, angle_delta_0..3
//  m_*  result    out  speed_cmd_0..3, correction_0..3
//  cfg_*          in   kp_gain, kd_gain, speed_scale, speed_limit, deadband
//
// A request is taken from the input stream, then each wheel runs a 10-step
// read-modify-write of its state entry through one 17x33 multiplier; the
// result then moves to the output register once that register is free.
// A new request is taken the cycle after the result moves to the output
// register, even if that result is still waiting on m_tready.
// Reset clears configuration to defaults and the state entries to zero
// through per-entry valid bits; no clearing pass.
`default_nettype none

module virtual_encoder_position_loop (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// target_speed_0..3, now_angle_0..3, angle_delta_0..3, zero pad
	input  wire logic [vepl_pkg::IN_W-1:0]       s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// speed_cmd_0..3, correction_0..3
	output logic      [vepl_pkg::OUT_W-1:0]      m_tdata,
	input  wire logic                            cfg_we,
	input  wire logic [vepl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [vepl_pkg::CFG_DATA_W-1:0] cfg_data
);

	import vepl_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_A    = 4'd2;
	localparam logic [3:0] ST_B    = 4'd3;
	localparam logic [3:0] ST_C    = 4'd4;
	localparam logic [3:0] ST_D    = 4'd5;
	localparam logic [3:0] ST_E    = 4'd6;
	localparam logic [3:0] ST_F    = 4'd7;
	localparam logic [3:0] ST_G    = 4'd8;
	localparam logic [3:0] ST_H    = 4'd9;
	localparam logic [3:0] ST_I    = 4'd10;
	localparam logic [3:0] ST_DONE = 4'd11;

	localparam logic signed [14:0] BAND_POS = 15'(WRAP_BAND);
	localparam logic signed [14:0] BAND_NEG = -BAND_POS;
	localparam logic signed [14:0] ENC15    = 15'(ENC_COUNTS);
	localparam logic [WHEEL_W-1:0] LAST_W   = WHEEL_W'(WHEELS - 1);

	// configuration
	logic [GAIN_W-1:0]  kp_q, kd_q, scale_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [DBAND_W-1:0] dband_q;

	// control
	logic [3:0]         state_q;
	logic [WHEEL_W-1:0] w_q;
	logic [WHEELS-1:0]  valid_q;
	logic [1:0]         zflag_q;
	logic               load_q;
	logic               rvld_q;

	// datapath
	logic [IN_W-1:0]          in_q;
	logic [OUT_W-1:0]         res_q;
	logic signed [49:0]       mul_q;
	logic signed [16:0]       mul_a;
	logic signed [32:0]       mul_b;
	logic signed [16:0]       step_q;
	logic [ANGLE_W-1:0]       vpn_q;
	logic [ERR_W-1:0]         err1_q, err_q, prev_q;
	logic signed [14:0]       diff_q;
	logic signed [32:0]       ed_q;
	logic signed [49:0]       acc_q;
	logic signed [50:0]       num_q;
	logic signed [42:0]       raw_q;
	logic signed [15:0]       clamp_q;

	wheel_state_t ram_rd, ram_wr;
	logic         ram_we;

	vepl_ram #(
		.WIDTH(STATE_W),
		.DEPTH(WHEELS)
	) u_state_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(w_q),
		.wdata(ram_wr),
		.raddr(w_q),
		.rdata(ram_rd)
	);

	// fields of the current wheel
	logic signed [SPEED_W-1:0] spd_w;
	logic [ANGLE_W-1:0]        now_w;
	logic signed [DELTA_W-1:0] delta_w;

	assign spd_w   = $signed(in_q[SPEED_W * w_q +: SPEED_W]);
	assign now_w   = in_q[NOW_LSB + ANGLE_W * w_q +: ANGLE_W];
	assign delta_w = $signed(in_q[DELTA_LSB + DELTA_W * w_q +: DELTA_W]);

	assign s_tready = (state_q == ST_IDLE);

	// step A: counts per tick, truncated toward zero
	logic signed [32:0]  sp_prod, sp_adj;
	logic signed [16:0]  step_w;
	logic [ANGLE_W-1:0]  base_w;
	logic [ERR_W-1:0]    pend_w;

	assign sp_prod = mul_q[32:0];
	assign sp_adj  = sp_prod + $signed({17'd0, {16{sp_prod[32]}}});
	assign step_w  = sp_adj[32:16];
	assign base_w  = load_q ? now_w : (rvld_q ? ram_rd.vpos : '0);
	assign pend_w  = rvld_q ? ram_rd.pend : '0;

	// step B: virtual minus real, folded into the wrap band
	logic [ANGLE_W-1:0]  real_w;
	logic signed [14:0]  dd_w;

	assign real_w = now_w + err1_q[ANGLE_W-1:0];
	assign dd_w   = $signed({2'b00, vpn_q}) - $signed({2'b00, real_w});

	// step G: divide by 256 toward zero
	logic signed [50:0] num_adj;
	assign num_adj = num_q + $signed({43'd0, {8{num_q[50]}}});

	// step H: clamp
	logic signed [42:0] lim43;
	logic signed [15:0] lim16;
	assign lim43 = $signed({28'd0, limit_q});
	assign lim16 = $signed({1'b0, limit_q});

	// step I: deadband and command saturation
	logic signed [16:0] c17, db17, cmd17;
	logic signed [15:0] corr_w, cmd_w;
	assign c17    = {clamp_q[15], clamp_q};
	assign db17   = $signed({7'd0, dband_q});
	assign corr_w = (c17 < db17 && c17 > -db17) ? 16'sd0 : clamp_q;
	assign cmd17  = {corr_w[15], corr_w} + {spd_w[15], spd_w};
	always_comb begin
		if (cmd17 > 17'sd32767) begin
			cmd_w = 16'sh7FFF;
		end else if (cmd17 < -17'sd32768) begin
			cmd_w = 16'sh8000;
		end else begin
			cmd_w = cmd17[15:0];
		end
	end

	// shared multiplier operands
	always_comb begin
		unique case (state_q)
			ST_RD: begin
				mul_a = $signed({1'b0, scale_q});
				mul_b = {{17{spd_w[15]}}, spd_w};
			end
			ST_D: begin
				mul_a = $signed({1'b0, kp_q});
				mul_b = $signed({err_q[31], err_q});
			end
			ST_E: begin
				mul_a = $signed({1'b0, kd_q});
				mul_b = ed_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign ram_we      = (state_q == ST_D);
	assign ram_wr.vpos = vpn_q;
	assign ram_wr.pend = err_q + {{15{step_q[16]}}, step_q};
	assign ram_wr.prev = err_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= 16'd256;
			kd_q    <= 16'd0;
			scale_q <= 16'd273;
			limit_q <= 15'd8000;
			dband_q <= 10'd70;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KP:    kp_q    <= cfg_data[GAIN_W-1:0];
				REG_KD:    kd_q    <= cfg_data[GAIN_W-1:0];
				REG_SCALE: scale_q <= cfg_data[GAIN_W-1:0];
				REG_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				REG_DBAND: dband_q <= cfg_data[DBAND_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			w_q      <= '0;
			valid_q  <= '0;
			zflag_q  <= 2'b11;
			load_q   <= 1'b0;
			rvld_q   <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			rvld_q <= valid_q[w_q];
			// output register refills in the same cycle the old result leaves
			if (state_q == ST_DONE && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						load_q  <= &zflag_q;
						w_q     <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_A;
				ST_A:  state_q <= ST_B;
				ST_B:  state_q <= ST_C;
				ST_C:  state_q <= ST_D;
				ST_D: begin
					valid_q[w_q] <= 1'b1;
					if (w_q[WHEEL_W-1:1] == '0) begin
						zflag_q[w_q[0]] <= (vpn_q == '0);
					end
					state_q <= ST_E;
				end
				ST_E: state_q <= ST_F;
				ST_F: state_q <= ST_G;
				ST_G: state_q <= ST_H;
				ST_H: state_q <= ST_I;
				ST_I: begin
					if (w_q == LAST_W) begin
						state_q <= ST_DONE;
					end else begin
						w_q     <= w_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_DONE: begin
					if (!m_tvalid || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (state_q == ST_IDLE && s_tvalid) begin
			in_q <= s_tdata;
		end
		if (state_q == ST_A) begin
			step_q <= step_w;
			vpn_q  <= base_w + step_w[ANGLE_W-1:0];
			err1_q <= pend_w - {{(ERR_W-DELTA_W){delta_w[DELTA_W-1]}}, delta_w};
			prev_q <= rvld_q ? ram_rd.prev : '0;
		end
		if (state_q == ST_B) begin
			if (dd_w < BAND_NEG) begin
				diff_q <= dd_w + ENC15;
			end else if (dd_w > BAND_POS) begin
				diff_q <= dd_w - ENC15;
			end else begin
				diff_q <= dd_w;
			end
		end
		if (state_q == ST_C) begin
			err_q <= err1_q + {{(ERR_W-15){diff_q[14]}}, diff_q};
		end
		if (state_q == ST_D) begin
			ed_q <= $signed({err_q[31], err_q}) - $signed({prev_q[31], prev_q});
		end
		if (state_q == ST_E) begin
			acc_q <= mul_q;
		end
		if (state_q == ST_F) begin
			num_q <= {acc_q[49], acc_q} - {mul_q[49], mul_q};
		end
		if (state_q == ST_G) begin
			raw_q <= num_adj[50:8];
		end
		if (state_q == ST_H) begin
			if (raw_q > lim43) begin
				clamp_q <= lim16;
			end else if (raw_q < -lim43) begin
				clamp_q <= -lim16;
			end else begin
				clamp_q <= raw_q[15:0];
			end
		end
		if (state_q == ST_I) begin
			res_q[SPEED_W * w_q +: SPEED_W]            <= cmd_w;
			res_q[CORR_LSB + SPEED_W * w_q +: SPEED_W] <= corr_w;
		end
		if (state_q == ST_DONE && (!m_tvalid || m_tready)) begin
			m_tdata <= res_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/vepl_checker.sv =====
// Port-level checks for virtual_encoder_position_loop, bound to the top level.
// Depends on vepl_pkg for stream widths.
`default_nettype none

module vepl_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       s_tvalid,
	input wire logic                       s_tready,
	input wire logic                       m_tvalid,
	input wire logic                       m_tready,
	input wire logic [vepl_pkg::OUT_W-1:0] m_tdata
);

	import vepl_pkg::*;

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one request in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

	// a result cannot appear right after a request
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result too early");

	// a new result only comes out of the busy phase
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result without work");

endmodule

bind virtual_encoder_position_loop vepl_checker u_vepl_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for virtual_encoder_position_loop: random and corner ticks
// go in through the request stream, results are checked against a wheel model.
// Depends on vepl_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;
	import vepl_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int PHASES        = 7;
	localparam int TICKS_PER_SET = 240;
	localparam int HOLD_CYCLES   = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_KP;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// register copies, reset values
	logic [GAIN_W-1:0]  kp_gain = 16'd256;
	logic [GAIN_W-1:0]  kd_gain = 16'd0;
	logic [GAIN_W-1:0]  speed_scale = 16'd273;
	logic [LIMIT_W-1:0] speed_limit = 15'd8000;
	logic [DBAND_W-1:0] deadband = 10'd70;

	// per-wheel loop state
	logic [ANGLE_W-1:0] virt_pos [WHEELS] = '{default: '0};
	logic [ERR_W-1:0]   pend_err [WHEELS] = '{default: '0};
	logic [ERR_W-1:0]   prev_err [WHEELS] = '{default: '0};

	// simulated wheel angles for the tracked stimulus
	logic [ANGLE_W-1:0] wheel_pos [WHEELS] = '{default: '0};

	logic [IN_W-1:0]  tick_q [$];
	logic [OUT_W-1:0] cmd_q [$];
	logic [OUT_W-1:0] want;

	int n_pushed = 0;
	int n_taken = 0;
	int res_cnt = 0;
	int n_bad = 0;
	int stall_cnt = 0;
	bit in_taken = 1'b0;
	bit out_taken = 1'b0;
	int in_gap = 0;
	int in_sent = 0;
	int out_wait = 0;
	int out_hold = 0;

	virtual_encoder_position_loop DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint wrap_counts(longint v);
		longint r;
		r = v % ENC_COUNTS;
		if (r < 0) r += ENC_COUNTS;
		return r;
	endfunction

	// one control tick through the loop; updates the wheel state
	function automatic logic [OUT_W-1:0] control_tick(logic [IN_W-1:0] d);
		longint spd [WHEELS];
		longint stp [WHEELS];
		longint nw, dl, e, rl, df, num, raw, lim, corr, cmd;
		logic [ERR_W-1:0] e32;
		logic [OUT_W-1:0] r;
		r = '0;
		for (int w = 0; w < WHEELS; w++) begin
			spd[w] = longint'($signed(d[SPEED_W*w +: SPEED_W]));
			stp[w] = (spd[w] * longint'(speed_scale)) / 65536;
		end
		// start-up: virtual encoders 0 and 1 both at zero reload from the measured angles
		if (virt_pos[0] == 0 && virt_pos[1] == 0)
			for (int w = 0; w < WHEELS; w++)
				virt_pos[w] = d[NOW_LSB + ANGLE_W*w +: ANGLE_W];
		for (int w = 0; w < WHEELS; w++)
			virt_pos[w] = ANGLE_W'(wrap_counts(longint'(virt_pos[w]) + stp[w]));
		for (int w = 0; w < WHEELS; w++) begin
			nw = longint'(d[NOW_LSB + ANGLE_W*w +: ANGLE_W]);
			dl = longint'($signed(d[DELTA_LSB + DELTA_W*w +: DELTA_W]));
			e32 = pend_err[w] - 32'(dl);
			e = longint'($signed(e32));
			rl = wrap_counts(nw + e);
			df = longint'(virt_pos[w]) - rl;
			if (df < -WRAP_BAND) df += ENC_COUNTS;
			else if (df > WRAP_BAND) df -= ENC_COUNTS;
			e32 = e32 + 32'(df);
			e = longint'($signed(e32));
			pend_err[w] = e32 + 32'(stp[w]);
			num = longint'(kp_gain) * e
				- longint'(kd_gain) * (e - longint'($signed(prev_err[w])));
			prev_err[w] = e32;
			raw = num / 256;
			lim = longint'(speed_limit);
			if (raw > lim) corr = lim;
			else if (raw < -lim) corr = -lim;
			else corr = raw;
			if (corr < longint'(deadband) && corr > -longint'(deadband)) corr = 0;
			cmd = corr + spd[w];
			if (cmd > 32767) cmd = 32767;
			else if (cmd < -32768) cmd = -32768;
			r[SPEED_W*w +: SPEED_W] = cmd[15:0];
			r[CORR_LSB + SPEED_W*w +: SPEED_W] = corr[15:0];
		end
		return r;
	endfunction

	// request driver
	always @(negedge clk) begin
		if (!s_tvalid || in_taken) begin
			if (in_gap > 0) begin
				in_gap = in_gap - 1;
				s_tvalid <= 1'b0;
			end else if (tick_q.size() > 0) begin
				s_tdata <= tick_q.pop_front();
				s_tvalid <= 1'b1;
				in_sent = in_sent + 1;
				in_gap = (((in_sent / 100) % 4) == 3) ? 0 : $urandom_range(0, 4);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver; two long hold-offs let the block back up into the input
	always @(negedge clk) begin
		if (out_taken) begin
			out_wait = (((res_cnt / 150) % 4) == 2) ? 0 : $urandom_range(0, 4);
			if (res_cnt == 500 || res_cnt == 1300) out_hold = HOLD_CYCLES;
		end
		if (out_hold > 0) begin
			out_hold = out_hold - 1;
			m_tready <= 1'b0;
		end else if (out_wait > 0) begin
			out_wait = out_wait - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		in_taken = arst_n && s_tvalid && s_tready;
		out_taken = arst_n && m_tvalid && m_tready;
		if (in_taken) begin
			cmd_q.push_back(control_tick(s_tdata));
			n_taken = n_taken + 1;
		end
		if (out_taken) begin
			if (cmd_q.size() == 0) begin
				n_bad = n_bad + 1;
				if (n_bad <= 10) $display("result %0d with no request pending: %h", res_cnt, m_tdata);
			end else begin
				want = cmd_q.pop_front();
				for (int f = 0; f < 2 * WHEELS; f++)
					if (m_tdata[SPEED_W*f +: SPEED_W] !== want[SPEED_W*f +: SPEED_W]) begin
						n_bad = n_bad + 1;
						if (n_bad <= 10)
							$display("result %0d %s_%0d: expected %0d, got %0d", res_cnt,
								(f < WHEELS) ? "speed_cmd" : "correction", f % WHEELS,
								$signed(want[SPEED_W*f +: SPEED_W]),
								$signed(m_tdata[SPEED_W*f +: SPEED_W]));
					end
			end
			res_cnt = res_cnt + 1;
		end
		if (in_taken || out_taken) stall_cnt = 0;
		else stall_cnt = stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_KP:    kp_gain = val;
			REG_KD:    kd_gain = val;
			REG_SCALE: speed_scale = val;
			REG_LIMIT: speed_limit = val[LIMIT_W-1:0];
			REG_DBAND: deadband = val[DBAND_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_gains(input int kp, input int kd, input int scale, input int lim,
		input int db);
		write_reg(REG_KP, CFG_DATA_W'(kp));
		write_reg(REG_KD, CFG_DATA_W'(kd));
		write_reg(REG_SCALE, CFG_DATA_W'(scale));
		write_reg(REG_LIMIT, CFG_DATA_W'(lim));
		write_reg(REG_DBAND, CFG_DATA_W'(db));
	endtask

	task automatic wait_idle();
		while (n_taken != n_pushed || cmd_q.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	// an all-zero tick (start-up reload stays armed), then field extremes mixed per wheel
	task automatic queue_corners();
		logic [SPEED_W-1:0] spd_x [5];
		logic [ANGLE_W-1:0] now_x [4];
		logic [DELTA_W-1:0] dl_x [4];
		logic [IN_W-1:0] d;
		spd_x = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
		now_x = '{13'd0, 13'd8191, 13'd1, 13'd4096};
		dl_x = '{14'h2000, 14'h1FFF, 14'h0000, 14'h3FFF};
		tick_q.push_back('0);
		n_pushed = n_pushed + 1;
		for (int k = 0; k < 7; k++) begin
			d = '0;
			for (int w = 0; w < WHEELS; w++) begin
				d[SPEED_W*w +: SPEED_W] = spd_x[(k + w) % 5];
				d[NOW_LSB + ANGLE_W*w +: ANGLE_W] = now_x[(3*k + w) % 4];
				d[DELTA_LSB + DELTA_W*w +: DELTA_W] = dl_x[(k + 2*w) % 4];
			end
			tick_q.push_back(d);
			n_pushed = n_pushed + 1;
		end
	endtask

	// mostly ticks where the measured angle follows the commanded motion, the rest noise
	task automatic queue_ticks(input int count);
		logic [SPEED_W-1:0] spd;
		logic [DELTA_W-1:0] dl;
		logic [IN_W-1:0] d;
		longint stp;
		int kind;
		for (int n = 0; n < count; n++) begin
			d = '0;
			kind = $urandom_range(0, 9);
			for (int w = 0; w < WHEELS; w++) begin
				if (kind < 7) begin
					if ($urandom_range(0, 7) == 0) spd = SPEED_W'($urandom);
					else spd = SPEED_W'(int'($urandom_range(0, 6000)) - 3000);
					stp = (longint'($signed(spd)) * longint'(speed_scale)) / 65536;
					dl = DELTA_W'(stp + longint'($urandom_range(0, 40)) - 20);
					wheel_pos[w] = wheel_pos[w] + ANGLE_W'(dl);
					d[NOW_LSB + ANGLE_W*w +: ANGLE_W] = wheel_pos[w];
				end else begin
					spd = SPEED_W'($urandom);
					dl = DELTA_W'($urandom);
					d[NOW_LSB + ANGLE_W*w +: ANGLE_W] = ANGLE_W'($urandom);
				end
				d[SPEED_W*w +: SPEED_W] = spd;
				d[DELTA_LSB + DELTA_W*w +: DELTA_W] = dl;
			end
			tick_q.push_back(d);
			n_pushed = n_pushed + 1;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) wait_idle();
			case (ph)
				0: ;
				1: load_gains(65535, 65535, 65535, 32767, 0);
				2: load_gains(0, 0, 0, 0, 1023);
				3: load_gains(1024, 256, 273, 16384, 0);
				default: load_gains($urandom_range(0, 4096), $urandom_range(0, 4096),
					$urandom_range(0, 65535), $urandom_range(0, 16384),
					$urandom_range(0, 1023));
			endcase
			if (ph < 3) queue_corners();
			queue_ticks(TICKS_PER_SET);
		end
		wait_idle();
		if (n_bad == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
